### rtl/lcrf_pkg.sv
// shared types and constants for the clipped rectangle fill sequencer
package lcrf_pkg;

    localparam int unsigned COORD_W = 16;
    localparam int unsigned DIM_W   = 11;
    localparam int unsigned WIN_W   = 10;

    localparam logic [DIM_W-1:0] DIM_LIMIT    = 11'd1024;
    localparam logic [DIM_W-1:0] PANEL_W_RST  = 11'd240;
    localparam logic [DIM_W-1:0] PANEL_H_RST  = 11'd320;

    localparam logic [7:0] CMD_COL_ADDR  = 8'h2A;
    localparam logic [7:0] CMD_ROW_ADDR  = 8'h2B;
    localparam logic [7:0] CMD_MEM_WRITE = 8'h2C;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_START = 1'b1
    } t_opcode;

    typedef enum logic {
        REG_PANEL_WIDTH  = 1'b0,
        REG_PANEL_HEIGHT = 1'b1
    } t_reg_index;

    typedef enum logic [3:0] {
        STEP_COL_CMD  = 4'd0,
        STEP_X0_HI    = 4'd1,
        STEP_X0_LO    = 4'd2,
        STEP_X1_HI    = 4'd3,
        STEP_X1_LO    = 4'd4,
        STEP_ROW_CMD  = 4'd5,
        STEP_Y0_HI    = 4'd6,
        STEP_Y0_LO    = 4'd7,
        STEP_Y1_HI    = 4'd8,
        STEP_Y1_LO    = 4'd9,
        STEP_MEM_CMD  = 4'd10,
        STEP_PIXELS   = 4'd11
    } t_hdr_step;

    typedef struct packed {
        logic                opcode;
        logic [COORD_W-1:0]  rect_x;
        logic [COORD_W-1:0]  rect_y;
        logic [COORD_W-1:0]  rect_w;
        logic [COORD_W-1:0]  rect_h;
        logic [COORD_W-1:0]  fill_colour;
    } t_in_item;

    typedef struct packed {
        logic        is_command;
        logic [7:0]  bus_byte;
        logic        is_last;
    } t_out_item;

endpackage

### rtl/lcd_clipped_rect_fill_sequencer.sv
// top level of the clipped rectangle fill sequencer
//
// input channel: one transaction per item, opcode start loads a rectangle and
// colour, opcode tick asks for the next bus byte. a start while a fill is in
// progress, a start whose origin is off the panel and a start with zero width
// or height are dropped. a tick while idle gives nothing.
// output channel: one transaction per bus byte, with command flag and last flag.
// each fill gives 11 header bytes then two colour bytes per clipped pixel.
// configuration: panel width and height via the plain write port, to be written by
// the user while the block is idle (not enforced); values above 1024 clip as 1024.
// throughput: one item per cycle while the output is not stalled, one byte per
// tick; the whole item is handled by the logic between the input register and
// the output register, which takes each byte as its tick leaves the input register.
// reset: synchronous, clears both pipeline valids, returns to idle and loads
// the panel size defaults 240 x 320.
// stall: a stalled output holds its byte; the input register keeps taking
// items while it is empty or the output register is free or being emptied,
// otherwise the input stall rises in the same cycle.
module lcd_clipped_rect_fill_sequencer
    import lcrf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_item,
    input  logic             i_cfg_wr_en,
    input  logic             i_cfg_index,
    input  logic [DIM_W-1:0] i_cfg_data
);

    logic [DIM_W-1:0] r_panel_w, r_panel_h;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;

    logic             r_busy, n_busy;
    t_hdr_step        r_step, n_step;
    logic             r_low_next, n_low_next;
    logic [WIN_W-1:0] r_x0, n_x0, r_x1, n_x1, r_y0, n_y0, r_y1, n_y1;
    logic [WIN_W-1:0] r_col_span, n_col_span;
    logic [WIN_W-1:0] r_col_cnt, n_col_cnt, r_row_cnt, n_row_cnt;
    logic [COORD_W-1:0] r_colour, n_colour;

    logic      go, take, produce;
    t_out_item n_out;

    logic [DIM_W-1:0]   pw, ph, pw_m1, ph_m1;
    logic [COORD_W:0]   x_sum, y_sum;
    logic [WIN_W-1:0]   x1_clip, y1_clip;
    logic               start_ok;

    assign go         = ~r_out_valid | ~i_out_stall;
    assign o_in_stall = r_in_valid & ~go;
    assign take       = r_in_valid & go;
    assign produce    = take & (r_in.opcode == OP_TICK) & r_busy;

    // clipping of the far corner
    always_comb begin
        pw    = (r_panel_w > DIM_LIMIT) ? DIM_LIMIT : r_panel_w;
        ph    = (r_panel_h > DIM_LIMIT) ? DIM_LIMIT : r_panel_h;
        pw_m1 = pw - 11'd1;
        ph_m1 = ph - 11'd1;
        x_sum = {1'b0, r_in.rect_x} + {1'b0, r_in.rect_w} - 17'd1;
        y_sum = {1'b0, r_in.rect_y} + {1'b0, r_in.rect_h} - 17'd1;
        x1_clip = (x_sum > {6'd0, pw_m1}) ? pw_m1[WIN_W-1:0] : x_sum[WIN_W-1:0];
        y1_clip = (y_sum > {6'd0, ph_m1}) ? ph_m1[WIN_W-1:0] : y_sum[WIN_W-1:0];
        start_ok = ~r_busy
                 & (r_in.rect_x < {5'd0, pw})
                 & (r_in.rect_y < {5'd0, ph})
                 & (r_in.rect_w != '0)
                 & (r_in.rect_h != '0);
    end

    // next state
    always_comb begin
        n_busy     = r_busy;
        n_step     = r_step;
        n_low_next = r_low_next;
        n_x0       = r_x0;
        n_x1       = r_x1;
        n_y0       = r_y0;
        n_y1       = r_y1;
        n_col_span = r_col_span;
        n_col_cnt  = r_col_cnt;
        n_row_cnt  = r_row_cnt;
        n_colour   = r_colour;
        if (take) begin
            if (r_in.opcode == OP_START) begin
                if (start_ok) begin
                    n_busy     = 1'b1;
                    n_step     = STEP_COL_CMD;
                    n_low_next = 1'b0;
                    n_x0       = r_in.rect_x[WIN_W-1:0];
                    n_x1       = x1_clip;
                    n_y0       = r_in.rect_y[WIN_W-1:0];
                    n_y1       = y1_clip;
                    n_col_span = x1_clip - r_in.rect_x[WIN_W-1:0];
                    n_col_cnt  = x1_clip - r_in.rect_x[WIN_W-1:0];
                    n_row_cnt  = y1_clip - r_in.rect_y[WIN_W-1:0];
                    n_colour   = r_in.fill_colour;
                end
            end else if (r_busy) begin
                if (r_step != STEP_PIXELS) begin
                    n_step = t_hdr_step'(r_step + 4'd1);
                end else if (!r_low_next) begin
                    n_low_next = 1'b1;
                end else begin
                    n_low_next = 1'b0;
                    if (r_col_cnt == '0 && r_row_cnt == '0) begin
                        n_busy = 1'b0;
                        n_step = STEP_COL_CMD;
                    end else if (r_col_cnt == '0) begin
                        n_col_cnt = r_col_span;
                        n_row_cnt = r_row_cnt - 10'd1;
                    end else begin
                        n_col_cnt = r_col_cnt - 10'd1;
                    end
                end
            end
        end
    end

    // byte selection
    always_comb begin
        n_out.is_command = 1'b0;
        n_out.is_last    = 1'b0;
        n_out.bus_byte   = '0;
        case (r_step)
            STEP_COL_CMD: begin
                n_out.is_command = 1'b1;
                n_out.bus_byte   = CMD_COL_ADDR;
            end
            STEP_X0_HI:   n_out.bus_byte = {6'd0, r_x0[9:8]};
            STEP_X0_LO:   n_out.bus_byte = r_x0[7:0];
            STEP_X1_HI:   n_out.bus_byte = {6'd0, r_x1[9:8]};
            STEP_X1_LO:   n_out.bus_byte = r_x1[7:0];
            STEP_ROW_CMD: begin
                n_out.is_command = 1'b1;
                n_out.bus_byte   = CMD_ROW_ADDR;
            end
            STEP_Y0_HI:   n_out.bus_byte = {6'd0, r_y0[9:8]};
            STEP_Y0_LO:   n_out.bus_byte = r_y0[7:0];
            STEP_Y1_HI:   n_out.bus_byte = {6'd0, r_y1[9:8]};
            STEP_Y1_LO:   n_out.bus_byte = r_y1[7:0];
            STEP_MEM_CMD: begin
                n_out.is_command = 1'b1;
                n_out.bus_byte   = CMD_MEM_WRITE;
            end
            STEP_PIXELS: begin
                if (!r_low_next) begin
                    n_out.bus_byte = r_colour[15:8];
                end else begin
                    n_out.bus_byte = r_colour[7:0];
                    n_out.is_last  = (r_col_cnt == '0) && (r_row_cnt == '0);
                end
            end
            default: n_out.bus_byte = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_panel_w   <= PANEL_W_RST;
            r_panel_h   <= PANEL_H_RST;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_busy      <= 1'b0;
            r_step      <= STEP_COL_CMD;
            r_low_next  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_index == REG_PANEL_WIDTH) begin
                    r_panel_w <= i_cfg_data;
                end else begin
                    r_panel_h <= i_cfg_data;
                end
            end
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (go) begin
                r_out_valid <= produce;
            end
            r_busy     <= n_busy;
            r_step     <= n_step;
            r_low_next <= n_low_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in <= i_in_item;
        end
        if (produce) begin
            r_out <= n_out;
        end
        r_x0       <= n_x0;
        r_x1       <= n_x1;
        r_y0       <= n_y0;
        r_y1       <= n_y1;
        r_col_span <= n_col_span;
        r_col_cnt  <= n_col_cnt;
        r_row_cnt  <= n_row_cnt;
        r_colour   <= n_colour;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

### rtl/lcrf_checker.sv
// port level checks for the clipped rectangle fill sequencer, with bind
module lcrf_checker
    import lcrf_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_item))
        else $error("output transaction changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_last_is_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.is_last |-> !o_out_item.is_command)
        else $error("last flag on a command byte");

    a_cmd_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.is_command |->
            (o_out_item.bus_byte == CMD_COL_ADDR) ||
            (o_out_item.bus_byte == CMD_ROW_ADDR) ||
            (o_out_item.bus_byte == CMD_MEM_WRITE))
        else $error("unknown command byte");

endmodule

bind lcd_clipped_rect_fill_sequencer lcrf_checker u_lcrf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
